@@ sv/skut_pkg.sv @@
// Shared types, defaults and the order compare for the sorted keyed upsert table.
package skut_pkg;

	localparam int DEFAULT_SLOTS = 32;

	localparam logic CMD_UPSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef struct packed {
		logic        [63:0] key;
		logic signed [63:0] order;
		logic        [63:0] payload;
	} entry_t;

	function automatic logic order_less(input logic signed [63:0] a, input logic signed [63:0] b);
		return a < b;
	endfunction

endpackage

@@ sv/skut_store.sv @@
// Entry memory: one write port, one read port, registered read data.
module skut_store #(
	parameter int SLOTS = skut_pkg::DEFAULT_SLOTS,
	parameter int AW    = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  skut_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output skut_pkg::entry_t rdata
);

	skut_pkg::entry_t mem_q [SLOTS];
	skut_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/sorted_keyed_upsert_table.sv @@
// Sorted keyed upsert table: entries kept in ascending order key in one entry memory.
// Upsert: a key scan over the stored entries, then entries moved one position at a time,
// then control states and the write; one item at a time.
// Read: the position is read only when it holds an entry. Both use the single read port
// of the entry memory; a stalled result beat holds the block until it is taken.
// Reset empties the table at once (count cleared); entry contents are not cleared.
module sorted_keyed_upsert_table #(
	parameter int TABLE_SLOTS = skut_pkg::DEFAULT_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic        [63:0] entry_key,
	input  logic signed [63:0] entry_order,
	input  logic        [63:0] entry_payload,
	input  logic        [4:0]  read_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [4:0]  final_position,
	output logic        [5:0]  entry_count,
	output logic               was_update,
	output logic               did_evict,
	output logic        [63:0] evicted_key,
	output logic               read_valid,
	output logic        [63:0] read_key,
	output logic signed [63:0] read_order,
	output logic        [63:0] read_payload
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int EW = CW + 1;
	localparam int PW = (CW > 5) ? CW : 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DN_RD,
		ST_DN_CHK,
		ST_UP_RD,
		ST_UP_CHK,
		ST_WRITE,
		ST_RD_ISS,
		ST_RD_DATA,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] iss_q;
	logic [AW-1:0] chk_q;
	logic          chk_vld_s1;
	logic [AW-1:0] pos_q;
	logic          moved_q;

	logic               cmd_q;
	logic        [63:0] key_q;
	logic signed [63:0] order_q;
	logic        [63:0] payload_q;
	logic        [4:0]  rpos_q;
	logic               found_q;
	logic               evict_q;
	logic        [63:0] evkey_q;
	logic               rvalid_q;
	skut_pkg::entry_t   rdat_q;

	logic [AW-1:0]      min_pos_q;
	logic signed [63:0] min_ord_q;
	logic [63:0]        min_key_q;

	logic               out_valid_q;
	logic [4:0]         final_position_q;
	logic [5:0]         entry_count_q;
	logic               was_update_q;
	logic               did_evict_q;
	logic [63:0]        evicted_key_q;
	logic               read_valid_q;
	logic [63:0]        read_key_q;
	logic signed [63:0] read_order_q;
	logic [63:0]        read_payload_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	skut_pkg::entry_t wr_data;
	skut_pkg::entry_t rd_data;

	logic          is_rd;
	logic          hit;
	logic          last;
	logic          full;
	logic          take_min;
	logic [AW-1:0] lo_pos;
	logic [63:0]   lo_key;
	logic          dn_move;
	logic          dn_more;
	logic          up_move;
	logic          up_ok;
	logic          up_more;
	logic          rpos_ok;
	logic          out_free;

	skut_store #(
		.SLOTS (TABLE_SLOTS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pos_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign is_rd    = cmd_q == skut_pkg::CMD_READ;
	assign hit      = chk_vld_s1 && (rd_data.key == key_q);
	assign last     = CW'(chk_q) == (count_q - CW'(1));
	assign full     = count_q == CW'(TABLE_SLOTS);
	assign take_min = (chk_q == '0) || skut_pkg::order_less(rd_data.order, min_ord_q);
	assign lo_pos   = take_min ? chk_q : min_pos_q;
	assign lo_key   = take_min ? rd_data.key : min_key_q;
	assign dn_move  = skut_pkg::order_less(order_q, rd_data.order);
	assign dn_more  = pos_q > AW'(1);
	assign up_move  = skut_pkg::order_less(rd_data.order, order_q);
	assign up_ok    = (EW'(pos_q) + EW'(1)) < EW'(count_q);
	assign up_more  = (EW'(pos_q) + EW'(2)) < EW'(count_q);
	assign rpos_ok  = PW'(rpos_q) < PW'(count_q);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q;
		wr_en   = 1'b0;
		wr_data = rd_data;
		case (state_q)
			ST_SCAN: begin
				rd_en   = (iss_q < count_q) && !hit;
				rd_addr = iss_q[AW-1:0];
			end
			ST_DN_RD: begin
				rd_en   = pos_q != '0;
				rd_addr = AW'(pos_q - AW'(1));
			end
			ST_DN_CHK: begin
				wr_en   = dn_move;
				rd_en   = dn_move && dn_more;
				rd_addr = AW'(pos_q - AW'(2));
			end
			ST_UP_RD: begin
				rd_en   = up_ok;
				rd_addr = AW'(pos_q + AW'(1));
			end
			ST_UP_CHK: begin
				wr_en   = up_move;
				rd_en   = up_move && up_more;
				rd_addr = AW'(pos_q + AW'(2));
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				wr_data = '{key: key_q, order: order_q, payload: payload_q};
			end
			ST_RD_ISS: begin
				rd_en   = rpos_ok;
				rd_addr = AW'(rpos_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			chk_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q      <= cmd;
						key_q      <= entry_key;
						order_q    <= entry_order;
						payload_q  <= entry_payload;
						rpos_q     <= read_position;
						found_q    <= 1'b0;
						evict_q    <= 1'b0;
						evkey_q    <= '0;
						rvalid_q   <= 1'b0;
						iss_q      <= '0;
						chk_vld_s1 <= 1'b0;
						if (cmd == skut_pkg::CMD_READ) begin
							state_q <= ST_RD_ISS;
						end else if (count_q == '0) begin
							pos_q   <= '0;
							count_q <= CW'(1);
							state_q <= ST_DN_RD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + CW'(1);
						chk_q <= iss_q[AW-1:0];
					end
					// no read is issued on a hit or on the last entry, so this clears
					chk_vld_s1 <= rd_en;
					if (chk_vld_s1) begin
						min_pos_q <= lo_pos;
						min_ord_q <= take_min ? rd_data.order : min_ord_q;
						min_key_q <= lo_key;
						if (hit) begin
							found_q <= 1'b1;
							pos_q   <= chk_q;
							state_q <= ST_DN_RD;
						end else if (last) begin
							if (full) begin
								evict_q <= 1'b1;
								evkey_q <= lo_key;
								pos_q   <= lo_pos;
							end else begin
								pos_q   <= AW'(count_q);
								count_q <= count_q + CW'(1);
							end
							state_q <= ST_DN_RD;
						end
					end
				end
				ST_DN_RD: begin
					moved_q <= 1'b0;
					state_q <= (pos_q == '0) ? ST_UP_RD : ST_DN_CHK;
				end
				ST_DN_CHK: begin
					if (dn_move) begin
						pos_q   <= AW'(pos_q - AW'(1));
						moved_q <= 1'b1;
						if (!dn_more) begin
							state_q <= ST_WRITE;
						end
					end else begin
						state_q <= moved_q ? ST_WRITE : ST_UP_RD;
					end
				end
				ST_UP_RD: begin
					state_q <= up_ok ? ST_UP_CHK : ST_WRITE;
				end
				ST_UP_CHK: begin
					if (up_move) begin
						pos_q <= AW'(pos_q + AW'(1));
						if (!up_more) begin
							state_q <= ST_WRITE;
						end
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_RD_ISS: begin
					rvalid_q <= rpos_ok;
					state_q  <= rpos_ok ? ST_RD_DATA : ST_DONE;
				end
				ST_RD_DATA: begin
					rdat_q  <= rd_data;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						final_position_q <= is_rd ? 5'd0 : 5'(pos_q);
						entry_count_q    <= 6'(count_q);
						was_update_q     <= !is_rd && found_q;
						did_evict_q      <= !is_rd && evict_q;
						evicted_key_q    <= (!is_rd && evict_q) ? evkey_q : 64'd0;
						read_valid_q     <= is_rd && rvalid_q;
						read_key_q       <= (is_rd && rvalid_q) ? rdat_q.key : 64'd0;
						read_order_q     <= (is_rd && rvalid_q) ? rdat_q.order : 64'sd0;
						read_payload_q   <= (is_rd && rvalid_q) ? rdat_q.payload : 64'd0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = state_q != ST_IDLE;
	assign out_valid      = out_valid_q;
	assign final_position = final_position_q;
	assign entry_count    = entry_count_q;
	assign was_update     = was_update_q;
	assign did_evict      = did_evict_q;
	assign evicted_key    = evicted_key_q;
	assign read_valid     = read_valid_q;
	assign read_key       = read_key_q;
	assign read_order     = read_order_q;
	assign read_payload   = read_payload_q;

endmodule
